>>> hw/rtl/gcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gcd_pkg - shared constants for the great-circle distance core
// Fixed-point formats, CORDIC arctangent table and pipeline stage map.
// ----------------------------------------------------------------------------
package gcd_pkg;

    localparam int CORDIC_STEPS = 32;
    localparam int SQRT_STEPS   = 32;
    localparam int LANES        = 4;

    localparam int ROT_W = 36;   // rotation CORDIC x/y/z
    localparam int VEC_W = 50;   // vectoring CORDIC x/y
    localparam int ANG_W = 36;   // vectoring CORDIC angle

    // stage map (index of the register that holds each step's result)
    localparam int ST_IN    = 0;
    localparam int ST_TURN  = 1;
    localparam int ST_FOLD  = 2;
    localparam int ST_ROT   = ST_FOLD + 1;
    localparam int ST_Q30   = ST_ROT + CORDIC_STEPS;
    localparam int ST_M1    = ST_Q30 + 1;
    localparam int ST_M2    = ST_M1 + 1;
    localparam int ST_M3    = ST_M2 + 1;
    localparam int ST_M4    = ST_M3 + 1;
    localparam int ST_SQRT  = ST_M4 + 1;
    localparam int ST_VEC   = ST_SQRT + SQRT_STEPS;
    localparam int ST_D1    = ST_VEC + CORDIC_STEPS;
    localparam int ST_D2    = ST_D1 + 1;
    localparam int ST_D3    = ST_D2 + 1;
    localparam int LATENCY  = ST_D3 + 1;

    localparam logic [32:0] DEG_TO_BAM   = 33'd6108397932;
    localparam logic [31:0] PI_Q30       = 32'd3373259426;
    localparam logic [31:0] CORDIC_GAIN  = 32'h9B74EDA8;
    localparam logic [31:0] RADIUS_RESET = 32'd417529856;

    // atan(2^-i) in 2^-32 turn
    function automatic logic [31:0] atan_turns(input int i);
        logic [31:0] r;
        case (i)
            0:  r = 32'h20000000;
            1:  r = 32'h12E4051E;
            2:  r = 32'h09FB385B;
            3:  r = 32'h051111D4;
            4:  r = 32'h028B0D43;
            5:  r = 32'h0145D7E1;
            6:  r = 32'h00A2F61E;
            7:  r = 32'h00517C55;
            8:  r = 32'h0028BE53;
            9:  r = 32'h00145F2F;
            10: r = 32'h000A2F98;
            11: r = 32'h000517CC;
            12: r = 32'h00028BE6;
            13: r = 32'h000145F3;
            14: r = 32'h0000A2FA;
            15: r = 32'h0000517D;
            16: r = 32'h000028BE;
            17: r = 32'h0000145F;
            18: r = 32'h00000A30;
            19: r = 32'h00000518;
            20: r = 32'h0000028C;
            21: r = 32'h00000146;
            22: r = 32'h000000A3;
            23: r = 32'h00000051;
            24: r = 32'h00000029;
            25: r = 32'h00000014;
            26: r = 32'h0000000A;
            27: r = 32'h00000005;
            28: r = 32'h00000003;
            29: r = 32'h00000001;
            30: r = 32'h00000001;
            default: r = 32'h00000000;
        endcase
        return r;
    endfunction

endpackage

>>> hw/rtl/great_circle_distance_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// great_circle_distance_core - haversine distance pipeline
// Degrees to turns, four rotation CORDIC lanes, products, two square roots,
// vectoring CORDIC atan2 and radius scaling, one register per step.
// ----------------------------------------------------------------------------
// Pipeline: 107 register stages from request accept to result valid (one
// per CORDIC step and per square-root digit, plus conversion and multiply
// stages; the first is loaded on the accept edge).
// Throughput: one request per cycle; the whole pipe holds while the output
// register is full and not taken.
// Reset: valid bits cleared, radius_reg back to 6371.0 km.
module great_circle_distance_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [30:0] lat_a,
    input  logic [31:0] lon_a,
    input  logic [30:0] lat_b,
    input  logic [31:0] lon_b,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] distance_km,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);
    import gcd_pkg::*;

    logic                    adv;
    logic [LATENCY-1:0]      vld_reg;
    logic [LATENCY-1:0]      eq_reg;
    logic [31:0]             radius_reg;

    logic signed [31:0]      lat_a_reg, lon_a_reg, lat_b_reg, lon_b_reg;
    logic [31:0]             ta_reg, tb_reg, ua_reg, ub_reg;

    logic signed [ROT_W-1:0] rx_reg [0:CORDIC_STEPS][0:LANES-1];
    logic signed [ROT_W-1:0] ry_reg [0:CORDIC_STEPS][0:LANES-1];
    logic signed [ROT_W-1:0] rz_reg [0:CORDIC_STEPS][0:LANES-1];
    logic [LANES-1:0]        flip_reg [0:CORDIC_STEPS];
    logic signed [ROT_W-1:0] rx_next [1:CORDIC_STEPS][0:LANES-1];
    logic signed [ROT_W-1:0] ry_next [1:CORDIC_STEPS][0:LANES-1];
    logic signed [ROT_W-1:0] rz_next [1:CORDIC_STEPS][0:LANES-1];

    logic signed [ROT_W-1:0] fz_next [0:LANES-1];
    logic [LANES-1:0]        fflip_next;

    logic signed [31:0]      ca_reg, cb_reg, slat_reg, slon_reg;
    logic signed [31:0]      q30_next [0:LANES-1];

    logic signed [63:0]      pprod_reg, sq1_reg, sq2_reg, sq3_reg, tprod_reg, tl_reg;
    logic signed [31:0]      slon1_reg, slon2_reg;
    logic signed [31:0]      p_next, t_next;
    logic signed [63:0]      p_full, t_full;
    logic signed [64:0]      acc_sum;
    logic [60:0]             acc_clamp;

    logic [63:0]             sv_reg [0:SQRT_STEPS][0:1];
    logic [63:0]             sr_reg [0:SQRT_STEPS][0:1];
    logic [63:0]             sv_next [1:SQRT_STEPS][0:1];
    logic [63:0]             sr_next [1:SQRT_STEPS][0:1];

    logic signed [VEC_W-1:0] vx_reg [1:CORDIC_STEPS];
    logic signed [VEC_W-1:0] vy_reg [1:CORDIC_STEPS];
    logic signed [ANG_W-1:0] vz_reg [1:CORDIC_STEPS];
    logic signed [VEC_W-1:0] vx_next [1:CORDIC_STEPS];
    logic signed [VEC_W-1:0] vy_next [1:CORDIC_STEPS];
    logic signed [ANG_W-1:0] vz_next [1:CORDIC_STEPS];

    logic [31:0]             zc;
    logic [63:0]             m_reg, hi_reg, lo_reg;
    logic [64:0]             dsum;
    logic [35:0]             dshift;
    logic [31:0]             dist_reg;

    function automatic logic [31:0] to_turns(input logic signed [31:0] deg);
        logic [63:0] p;
        p = 64'(deg) * 64'(DEG_TO_BAM) + 64'h0000_0000_8000_0000;
        return p[63:32];
    endfunction

    function automatic logic signed [63:0] rnd30(input logic signed [63:0] v);
        logic signed [63:0] s;
        s = v + 64'sd536870912;
        return s >>> 30;
    endfunction

    assign adv      = !vld_reg[LATENCY-1] || out_ready;
    assign in_ready = adv;
    assign out_valid   = vld_reg[LATENCY-1];
    assign distance_km = dist_reg;

    // ---------------- combinational step logic ----------------
    always_comb
    begin
        logic signed [ROT_W-1:0] z0 [0:LANES-1];
        logic signed [ROT_W-1:0] dx, dy, da, v, s;
        logic signed [VEC_W-1:0] vdx, vdy, vx0, vy0;
        logic [63:0]             bit_k, trial;
        z0[0] = {{3{ta_reg[31]}}, ta_reg, 1'b0};
        z0[1] = {{3{tb_reg[31]}}, tb_reg, 1'b0};
        z0[2] = ROT_W'($signed(tb_reg - ta_reg));
        z0[3] = ROT_W'($signed(ub_reg - ua_reg));
        for (int l = 0; l < LANES; l++)
        begin
            // fold into a quarter turn either side of zero
            if (z0[l] > $signed(ROT_W'(64'h8000_0000)))
            begin
                fz_next[l]    = z0[l] - $signed(ROT_W'(64'h1_0000_0000));
                fflip_next[l] = 1'b1;
            end
            else if (z0[l] < -$signed(ROT_W'(64'h8000_0000)))
            begin
                fz_next[l]    = z0[l] + $signed(ROT_W'(64'h1_0000_0000));
                fflip_next[l] = 1'b1;
            end
            else
            begin
                fz_next[l]    = z0[l];
                fflip_next[l] = 1'b0;
            end
        end

        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            da = {3'b000, atan_turns(i), 1'b0};
            for (int l = 0; l < LANES; l++)
            begin
                dx = ry_reg[i][l] >>> i;
                dy = rx_reg[i][l] >>> i;
                if (rz_reg[i][l] >= 0)
                begin
                    rx_next[i+1][l] = rx_reg[i][l] - dx;
                    ry_next[i+1][l] = ry_reg[i][l] + dy;
                    rz_next[i+1][l] = rz_reg[i][l] - da;
                end
                else
                begin
                    rx_next[i+1][l] = rx_reg[i][l] + dx;
                    ry_next[i+1][l] = ry_reg[i][l] - dy;
                    rz_next[i+1][l] = rz_reg[i][l] + da;
                end
            end
        end

        // Q30 rounding: lanes 0,1 take cosine, lanes 2,3 take sine
        for (int l = 0; l < LANES; l++)
        begin
            v = (l < 2) ? rx_reg[CORDIC_STEPS][l] : ry_reg[CORDIC_STEPS][l];
            if (flip_reg[CORDIC_STEPS][l])
                v = -v;
            s = (v + $signed(ROT_W'(2))) >>> 2;
            if (s > $signed(ROT_W'(64'h4000_0000)))
                s = ROT_W'(64'h4000_0000);
            if (s < -$signed(ROT_W'(64'h4000_0000)))
                s = -$signed(ROT_W'(64'h4000_0000));
            q30_next[l] = s[31:0];
        end

        p_full = rnd30(pprod_reg);
        t_full = rnd30(tprod_reg);
        p_next = p_full[31:0];
        t_next = t_full[31:0];

        acc_sum = 65'(sq3_reg) + 65'(tl_reg);
        if (acc_sum < 0)
            acc_clamp = '0;
        else if (acc_sum > $signed(65'h1000_0000_0000_0000))
            acc_clamp = 61'h1000_0000_0000_0000;
        else
            acc_clamp = acc_sum[60:0];

        for (int k = 0; k < SQRT_STEPS; k++)
        begin
            bit_k = 64'd1 << (62 - 2 * k);
            for (int l = 0; l < 2; l++)
            begin
                trial = sr_reg[k][l] + bit_k;
                if (sv_reg[k][l] >= trial)
                begin
                    sv_next[k+1][l] = sv_reg[k][l] - trial;
                    sr_next[k+1][l] = (sr_reg[k][l] >> 1) + bit_k;
                end
                else
                begin
                    sv_next[k+1][l] = sv_reg[k][l];
                    sr_next[k+1][l] = sr_reg[k][l] >> 1;
                end
            end
        end

        // vectoring: x from sqrt(1-a), y from sqrt(a)
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            da = {3'b000, atan_turns(i), 1'b0};
            if (i == 0)
            begin
                vx0 = VEC_W'({sr_reg[SQRT_STEPS][1][31:0], 16'h0000});
                vy0 = VEC_W'({sr_reg[SQRT_STEPS][0][31:0], 16'h0000});
                vz_next[1] = '0;
            end
            else
            begin
                vx0 = vx_reg[i];
                vy0 = vy_reg[i];
                vz_next[i+1] = vz_reg[i];
            end
            vdx = vy0 >>> i;
            vdy = vx0 >>> i;
            if (vy0 >= 0)
            begin
                vx_next[i+1] = vx0 + vdx;
                vy_next[i+1] = vy0 - vdy;
                vz_next[i+1] = vz_next[i+1] + da;
            end
            else
            begin
                vx_next[i+1] = vx0 - vdx;
                vy_next[i+1] = vy0 + vdy;
                vz_next[i+1] = vz_next[i+1] - da;
            end
        end

        if (vz_reg[CORDIC_STEPS] < 0)
            zc = '0;
        else if (vz_reg[CORDIC_STEPS] > $signed(ANG_W'(64'h8000_0000)))
            zc = 32'h8000_0000;
        else
            zc = vz_reg[CORDIC_STEPS][31:0];

        dsum   = 65'(hi_reg) + 65'(lo_reg[63:32]);
        dshift = dsum[64:29];
    end

    // ---------------- control ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            radius_reg <= RADIUS_RESET;
        end
        else
        begin
            if (cfg_we)
                radius_reg <= cfg_wdata;
            if (adv)
                vld_reg <= {vld_reg[LATENCY-2:0], in_valid};
        end
    end

    // ---------------- datapath ----------------
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            eq_reg <= {eq_reg[LATENCY-2:0], (lat_a == lat_b) && (lon_a == lon_b)};

            lat_a_reg <= 32'($signed(lat_a));
            lon_a_reg <= $signed(lon_a);
            lat_b_reg <= 32'($signed(lat_b));
            lon_b_reg <= $signed(lon_b);

            ta_reg <= to_turns(lat_a_reg);
            tb_reg <= to_turns(lat_b_reg);
            ua_reg <= to_turns(lon_a_reg);
            ub_reg <= to_turns(lon_b_reg);

            for (int l = 0; l < LANES; l++)
            begin
                rx_reg[0][l] <= ROT_W'(CORDIC_GAIN);
                ry_reg[0][l] <= '0;
                rz_reg[0][l] <= fz_next[l];
            end
            flip_reg[0] <= fflip_next;
            for (int i = 1; i <= CORDIC_STEPS; i++)
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    rx_reg[i][l] <= rx_next[i][l];
                    ry_reg[i][l] <= ry_next[i][l];
                    rz_reg[i][l] <= rz_next[i][l];
                end
                flip_reg[i] <= flip_reg[i-1];
            end

            ca_reg   <= q30_next[0];
            cb_reg   <= q30_next[1];
            slat_reg <= q30_next[2];
            slon_reg <= q30_next[3];

            pprod_reg <= 64'(ca_reg) * 64'(cb_reg);
            sq1_reg   <= 64'(slat_reg) * 64'(slat_reg);
            slon1_reg <= slon_reg;

            tprod_reg <= 64'(p_next) * 64'(slon1_reg);
            sq2_reg   <= sq1_reg;
            slon2_reg <= slon1_reg;

            tl_reg  <= 64'(t_next) * 64'(slon2_reg);
            sq3_reg <= sq2_reg;

            sv_reg[0][0] <= {1'b0, acc_clamp, 2'b00};
            sv_reg[0][1] <= {1'b0, 61'h1000_0000_0000_0000 - acc_clamp, 2'b00};
            sr_reg[0][0] <= '0;
            sr_reg[0][1] <= '0;
            for (int k = 1; k <= SQRT_STEPS; k++)
            begin
                for (int l = 0; l < 2; l++)
                begin
                    sv_reg[k][l] <= sv_next[k][l];
                    sr_reg[k][l] <= sr_next[k][l];
                end
            end

            for (int i = 1; i <= CORDIC_STEPS; i++)
            begin
                vx_reg[i] <= vx_next[i];
                vy_reg[i] <= vy_next[i];
                vz_reg[i] <= vz_next[i];
            end

            m_reg  <= 64'(radius_reg) * 64'(zc);
            hi_reg <= 64'(m_reg[63:32]) * 64'(PI_Q30);
            lo_reg <= 64'(m_reg[31:0]) * 64'(PI_Q30) + 64'h1000_0000_0000_0000;

            if (eq_reg[ST_D2])
                dist_reg <= '0;
            else if (dshift[35:32] != 4'h0)
                dist_reg <= 32'hFFFF_FFFF;
            else
                dist_reg <= dshift[31:0];
        end
    end

    // ---------------- checks ----------------
    a_same_point_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && eq_reg[LATENCY-1] |-> distance_km == 32'h0)
        else $error("identical points gave nonzero distance");

    a_sqrt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[ST_VEC-1] |-> sr_reg[SQRT_STEPS][0] <= 64'h8000_0000
                              && sr_reg[SQRT_STEPS][1] <= 64'h8000_0000)
        else $error("square root out of range");

    a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> vld_reg[ST_IN])
        else $error("accepted request not captured");

endmodule
